// ===== src/preemptive_priority_task_queue_unit_defines.svh =====
// Assertion macros for the preemptive priority task queue unit
`ifndef PREEMPTIVE_PRIORITY_TASK_QUEUE_UNIT_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_TASK_QUEUE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define PPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PPQ_ASSERT(lbl, prop, msg)
`define PPQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== src/ppq_pkg.sv =====
// Package: types, codes and defaults of the preemptive priority task queue unit
`timescale 1ns / 1ps
package ppq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int NEST_DEPTH_DEF  = 8;
  localparam logic [15:0] IDLE_RESET = 16'd9999;

  localparam logic [1:0] ACT_ADD      = 2'd0;
  localparam logic [1:0] ACT_DISPATCH = 2'd1;
  localparam logic [1:0] ACT_FINISH   = 2'd2;

  localparam logic [2:0] STAT_OK          = 3'd0;
  localparam logic [2:0] STAT_QUEUE_FULL  = 3'd1;
  localparam logic [2:0] STAT_NO_PREEMPT  = 3'd2;
  localparam logic [2:0] STAT_NEST_FULL   = 3'd3;
  localparam logic [2:0] STAT_NOT_RUNNING = 3'd4;

  typedef struct packed {
    logic [7:0]  handle;
    logic [15:0] prio;
  } ppq_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_CMP,
    ST_ADD_PUT,
    ST_DSP_CHK,
    ST_FIN_SET,
    ST_DONE
  } ppq_state_t;

endpackage

// ===== src/ppq_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module ppq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/preemptive_priority_task_queue_unit.sv =====
// Top level: sorted task queue with preemptive dispatch and level nesting stack
//
//  channel  | direction | handshake          | contents
//  s_*      | in        | s_tvalid/s_tready  | tuser: action; tdata: handle, priority
//  m_*      | out       | m_tvalid/m_tready  | tdata: status .. queued count
//  cfg_*    | in        | cfg_wen            | cfg_wdata: idle level
//
// Add walks the queue from the tail through the queue RAM read port, one entry a cycle.
// Dispatch and finish pass through one check or update state before the result state;
// a rejected or unused action goes to it directly. Reset clears counts, pointers and the
// running level (to the idle level reset value); RAM contents are not cleared.
// A stalled result holds in the output register; one more item may be taken meanwhile.
`timescale 1ns / 1ps
`include "preemptive_priority_task_queue_unit_defines.svh"
module preemptive_priority_task_queue_unit
  import ppq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int NEST_DEPTH  = NEST_DEPTH_DEF,
  localparam int CW = $clog2(QUEUE_DEPTH + 1),
  localparam int OUT_W = ((44 + CW + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [23:0]      s_tdata,   // task_handle[7:0], priority_req[23:8]
  input  logic [1:0]       s_tuser,   // action[1:0]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // status, started, started_handle,
                                      // started_priority, running_level, queued_count
  input  logic             cfg_wen,
  input  logic [15:0]      cfg_wdata
);

  localparam int PW  = $clog2(QUEUE_DEPTH);
  localparam int SW  = PW + 1;
  localparam int DW  = $clog2(NEST_DEPTH + 1);
  localparam int NIW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

  ppq_state_t state, state_next;

  logic [PW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] k, k_next;
  logic [DW-1:0] depth, depth_next;
  logic [15:0]   cur_level, cur_level_next;

  logic [1:0]    act, act_next;
  ppq_entry_t    req, req_next;

  logic [2:0]    res_status, res_status_next;
  logic          res_started, res_started_next;
  ppq_entry_t    res_entry, res_entry_next;

  logic          m_tvalid_next;
  logic          out_load;
  logic [2:0]    o_status;
  logic          o_started;
  ppq_entry_t    o_entry;
  logic [15:0]   o_level;
  logic [CW-1:0] o_count;

  logic             q_we;
  logic [PW-1:0]    q_waddr, q_raddr;
  ppq_entry_t       q_wdata, q_rdata;
  logic             n_we;
  logic [NIW-1:0]   n_waddr, n_raddr;
  logic [15:0]      n_wdata, n_rdata;

  function automatic logic [PW-1:0] phys(input logic [PW-1:0] h, input logic [CW-1:0] l);
    logic [SW-1:0] sum;
    sum = SW'(h) + SW'(l);
    if (sum >= SW'(QUEUE_DEPTH)) begin
      sum = sum - SW'(QUEUE_DEPTH);
    end
    return PW'(sum);
  endfunction

  ppq_ram #(.WIDTH($bits(ppq_entry_t)), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  ppq_ram #(.WIDTH(16), .DEPTH(NEST_DEPTH)) u_nest_ram (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_waddr),
    .wdata (n_wdata),
    .raddr (n_raddr),
    .rdata (n_rdata)
  );

  assign s_tready = (state == ST_IDLE);
  assign n_raddr  = NIW'(depth - DW'(1));
  assign m_tdata  = OUT_W'({o_count, o_level, o_entry.prio, o_entry.handle, o_started, o_status});

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      count     <= '0;
      depth     <= '0;
      cur_level <= IDLE_RESET;
      m_tvalid  <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      count     <= count_next;
      depth     <= depth_next;
      cur_level <= cur_level_next;
      m_tvalid  <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    k           <= k_next;
    act         <= act_next;
    req         <= req_next;
    res_status  <= res_status_next;
    res_started <= res_started_next;
    res_entry   <= res_entry_next;
    if (out_load) begin
      o_status  <= res_status;
      o_started <= res_started;
      o_entry   <= res_entry;
      o_level   <= cur_level;
      o_count   <= count;
    end
  end

  always_comb begin
    state_next       = state;
    head_next        = head;
    count_next       = count;
    k_next           = k;
    depth_next       = depth;
    cur_level_next   = cur_level;
    act_next         = act;
    req_next         = req;
    res_status_next  = res_status;
    res_started_next = res_started;
    res_entry_next   = res_entry;
    m_tvalid_next    = m_tvalid && !m_tready;
    out_load         = 1'b0;
    q_we             = 1'b0;
    q_waddr          = phys(head, k);
    q_wdata          = req;
    q_raddr          = head;
    n_we             = 1'b0;
    n_waddr          = NIW'(depth);
    n_wdata          = cur_level;

    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          act_next         = s_tuser;
          req_next.handle  = s_tdata[7:0];
          req_next.prio    = s_tdata[23:8];
          res_status_next  = STAT_OK;
          res_started_next = 1'b0;
          res_entry_next   = '0;
          state_next       = ST_DONE;
          case (s_tuser)
            ACT_ADD: begin
              k_next = count;
              if (count == CW'(QUEUE_DEPTH)) begin
                res_status_next = STAT_QUEUE_FULL;
              end else if (count == '0) begin
                state_next = ST_ADD_PUT;
              end else begin
                state_next = ST_ADD_RD;
              end
            end
            ACT_DISPATCH: begin
              if (count == '0) begin
                res_status_next = STAT_NO_PREEMPT;
              end else begin
                state_next = ST_DSP_CHK;
              end
            end
            ACT_FINISH: begin
              if (depth == '0) begin
                res_status_next = STAT_NOT_RUNNING;
              end else begin
                state_next = ST_FIN_SET;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_ADD_RD: begin
        q_raddr    = phys(head, k - CW'(1));
        state_next = ST_ADD_CMP;
      end
      ST_ADD_CMP: begin
        q_raddr = phys(head, k - CW'(2));
        if (q_rdata.prio > req.prio) begin
          q_we    = 1'b1;
          q_wdata = q_rdata;
          k_next  = k - CW'(1);
          if (k == CW'(1)) begin
            state_next = ST_ADD_PUT;
          end
        end else begin
          state_next = ST_ADD_PUT;
        end
      end
      ST_ADD_PUT: begin
        q_we       = 1'b1;
        count_next = count + CW'(1);
        state_next = ST_DONE;
      end
      ST_DSP_CHK: begin
        state_next = ST_DONE;
        if (q_rdata.prio >= cur_level) begin
          res_status_next = STAT_NO_PREEMPT;
        end else if (depth == DW'(NEST_DEPTH)) begin
          res_status_next = STAT_NEST_FULL;
        end else begin
          res_started_next = 1'b1;
          res_entry_next   = q_rdata;
          head_next        = phys(head, CW'(1));
          count_next       = count - CW'(1);
          n_we             = 1'b1;
          depth_next       = depth + DW'(1);
          cur_level_next   = q_rdata.prio;
        end
      end
      ST_FIN_SET: begin
        depth_next     = depth - DW'(1);
        cur_level_next = n_rdata;
        state_next     = ST_DONE;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load      = 1'b1;
          m_tvalid_next = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (cfg_wen) begin
      if (depth == '0) begin
        cur_level_next = cfg_wdata;
      end else begin
        n_we    = 1'b1;
        n_waddr = '0;
        n_wdata = cfg_wdata;
      end
    end
  end

  `PPQ_ASSERT(a_count_bound, count <= CW'(QUEUE_DEPTH), "queue count beyond depth")
  `PPQ_ASSERT(a_depth_bound, depth <= DW'(NEST_DEPTH), "nesting depth beyond stack size")
  `PPQ_ASSERT(a_count_step, count != $past(count) |-> (count == $past(count) + CW'(1)) || (count + CW'(1) == $past(count)), "queue count moved by more than one")
  `PPQ_ASSERT(a_started_ok, m_tvalid && o_started |-> o_status == STAT_OK, "started item without ok status")
  `PPQ_ASSERT(a_started_level, m_tvalid && o_started |-> o_level == o_entry.prio, "running level differs from started priority")

endmodule

// ===== tb/sv/ppq_outcome_checker.sv =====
// Checker for the task queue unit: tracks queue and nesting state and compares every result item
`timescale 1ns / 1ps
module ppq_outcome_checker
  import ppq_pkg::*;
#(
  parameter int RES_W = 56
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [23:0]      s_tdata,
  input  logic [1:0]       s_tuser,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [RES_W-1:0] m_tdata,
  input  logic             cfg_wen,
  input  logic [15:0]      cfg_wdata,
  output int               fail_count,
  output int               pending_count
);

  typedef struct packed {
    logic [4:0]  queued;
    logic [15:0] level;
    logic [15:0] sprio;
    logic [7:0]  shandle;
    logic        started;
    logic [2:0]  status;
  } outcome_t;

  logic [15:0] q_prio [QUEUE_DEPTH_DEF];
  logic [7:0]  q_handle [QUEUE_DEPTH_DEF];
  int          q_len;
  logic [15:0] run_level;
  logic [15:0] saved_level [NEST_DEPTH_DEF];
  int          nest_len;
  logic [15:0] idle_reg;

  outcome_t pending_outcomes [$];
  int fails = 0;
  int waiting = 0;

  assign fail_count = fails;
  assign pending_count = waiting;

  function automatic outcome_t next_outcome(input logic [1:0] act, input logic [7:0] h,
                                            input logic [15:0] p);
    outcome_t r;
    int pos;
    r = '0;
    r.status = STAT_OK;
    case (act)
      ACT_ADD: begin
        if (q_len >= QUEUE_DEPTH_DEF) begin
          r.status = STAT_QUEUE_FULL;
        end else begin
          pos = 0;
          while (pos < q_len && q_prio[pos] <= p) pos++;
          for (int k = q_len; k > pos; k--) begin
            q_prio[k] = q_prio[k-1];
            q_handle[k] = q_handle[k-1];
          end
          q_prio[pos] = p;
          q_handle[pos] = h;
          q_len++;
        end
      end
      ACT_DISPATCH: begin
        if (q_len == 0 || q_prio[0] >= run_level) begin
          r.status = STAT_NO_PREEMPT;
        end else if (nest_len >= NEST_DEPTH_DEF) begin
          r.status = STAT_NEST_FULL;
        end else begin
          r.started = 1'b1;
          r.shandle = q_handle[0];
          r.sprio = q_prio[0];
          for (int k = 1; k < q_len; k++) begin
            q_prio[k-1] = q_prio[k];
            q_handle[k-1] = q_handle[k];
          end
          q_len--;
          saved_level[nest_len] = run_level;
          nest_len++;
          run_level = r.sprio;
        end
      end
      ACT_FINISH: begin
        if (nest_len == 0) begin
          r.status = STAT_NOT_RUNNING;
        end else begin
          nest_len--;
          run_level = saved_level[nest_len];
        end
      end
      default: ;
    endcase
    r.level = run_level;
    r.queued = q_len[4:0];
    return r;
  endfunction

  task automatic report_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    if (rst) begin
      q_len = 0;
      nest_len = 0;
      idle_reg = IDLE_RESET;
      run_level = IDLE_RESET;
      pending_outcomes.delete();
    end else begin
      if (cfg_wen) begin
        idle_reg = cfg_wdata;
        if (nest_len == 0) run_level = cfg_wdata;
        else saved_level[0] = cfg_wdata;
      end
      if (m_tvalid && m_tready) begin
        got = outcome_t'(m_tdata[$bits(outcome_t)-1:0]);
        if (pending_outcomes.size() == 0) begin
          $display("%0t ns: result expected none actual %h", $time, m_tdata);
          fails++;
        end else begin
          want = pending_outcomes.pop_front();
          report_field("status", 16'(want.status), 16'(got.status));
          report_field("started", 16'(want.started), 16'(got.started));
          report_field("started_handle", 16'(want.shandle), 16'(got.shandle));
          report_field("started_priority", want.sprio, got.sprio);
          report_field("running_level", want.level, got.level);
          report_field("queued_count", 16'(want.queued), 16'(got.queued));
          report_field("padding", 16'h0000, 16'(m_tdata[RES_W-1:$bits(outcome_t)]));
        end
      end
      if (s_tvalid && s_tready)
        pending_outcomes.push_back(next_outcome(s_tuser, s_tdata[7:0], s_tdata[23:8]));
    end
    waiting = pending_outcomes.size();
  end

endmodule

// ===== tb/sv/preemptive_priority_task_queue_unit_tb.sv =====
// Testbench top: drives task queue actions and idle level writes, then reports the verdict
`timescale 1ns / 1ps
module preemptive_priority_task_queue_unit_tb
  import ppq_pkg::*;
();

  localparam int RES_W = 56;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SEG_ITEMS = 150;
  localparam logic [1:0] ACT_RESERVED = 2'd3;

  logic             clk;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [23:0]      s_tdata = '0;
  logic [1:0]       s_tuser = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [RES_W-1:0] m_tdata;
  logic             cfg_wen = 1'b0;
  logic [15:0]      cfg_wdata = '0;
  int               fail_count;
  int               pending_count;

  int tx_idle_pct = 13;
  int rx_idle_pct = 76;
  int idle_now = IDLE_RESET;
  int sent_count = 0;

  preemptive_priority_task_queue_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  ppq_outcome_checker #(.RES_W(RES_W)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("preemptive_priority_task_queue_unit: mismatch");
    $finish;
  end

  task automatic send_item(input logic [1:0] act, input logic [7:0] h, input logic [15:0] p);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {p, h};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_count++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (24) @(negedge clk);
  endtask

  task automatic write_idle(input logic [15:0] v);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    idle_now = v;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  function automatic logic [15:0] pick_prio();
    int r;
    int near;
    r = $urandom_range(99);
    if (r < 10) begin
      case ($urandom_range(3))
        0: return 16'h0000;
        1: return 16'h0001;
        2: return 16'hFFFE;
        default: return 16'hFFFF;
      endcase
    end
    if (r < 40) return 16'($urandom_range(15));
    if (r < 52) begin
      near = idle_now + $urandom_range(2) - 1;
      if (near < 0) near = 0;
      if (near > 65535) near = 65535;
      return 16'(near);
    end
    return 16'($urandom_range(65535));
  endfunction

  task automatic run_segment(input int n_items);
    int stop_at;
    int kind;
    int depth;
    int p;
    int base;
    stop_at = sent_count + n_items;
    while (sent_count < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 25) begin
        depth = $urandom_range(1, 10);
        p = $urandom_range(0, idle_now);
        for (int k = 0; k < depth; k++) begin
          send_item(ACT_ADD, 8'($urandom_range(255)), 16'(p));
          send_item(ACT_DISPATCH, 8'($urandom_range(255)), 16'($urandom_range(65535)));
          if (p > 0) p = $urandom_range(0, p - 1);
        end
        repeat ($urandom_range(0, depth + 2))
          send_item(ACT_FINISH, 8'($urandom_range(255)), 16'($urandom_range(65535)));
      end else if (kind < 42) begin
        base = $urandom_range(65535);
        repeat ($urandom_range(4, 20)) begin
          p = ($urandom_range(1)) ? base + $urandom_range(3) : pick_prio();
          send_item(ACT_ADD, 8'($urandom_range(255)), 16'(p));
        end
        repeat ($urandom_range(0, 4))
          send_item(ACT_DISPATCH, 8'($urandom_range(255)), 16'($urandom_range(65535)));
      end else if (kind < 52) begin
        repeat ($urandom_range(1, 8)) begin
          send_item(ACT_DISPATCH, 8'($urandom_range(255)), 16'($urandom_range(65535)));
          send_item(ACT_FINISH, 8'($urandom_range(255)), 16'($urandom_range(65535)));
        end
      end else begin
        kind = $urandom_range(99);
        if (kind < 45)
          send_item(ACT_ADD, 8'($urandom_range(255)), pick_prio());
        else if (kind < 75)
          send_item(ACT_DISPATCH, 8'($urandom_range(255)), 16'($urandom_range(65535)));
        else if (kind < 95)
          send_item(ACT_FINISH, 8'($urandom_range(255)), 16'($urandom_range(65535)));
        else
          send_item(ACT_RESERVED, 8'($urandom_range(255)), 16'($urandom_range(65535)));
      end
    end
  endtask

  initial begin
    logic [15:0] levels [9];
    levels[0] = 16'hFFFF;
    levels[1] = 16'h0000;
    levels[2] = 16'd16;
    levels[3] = 16'($urandom_range(65535));
    levels[4] = IDLE_RESET;
    levels[5] = 16'd300;
    levels[6] = 16'($urandom_range(65535));
    levels[7] = 16'hFFFE;
    levels[8] = 16'd40000;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(ACT_FINISH, 8'h00, 16'h0000);
    send_item(ACT_DISPATCH, 8'h00, 16'h0000);
    send_item(ACT_RESERVED, 8'hFF, 16'hFFFF);
    send_item(ACT_ADD, 8'hFF, 16'hFFFF);
    send_item(ACT_DISPATCH, 8'h00, 16'h0000);
    send_item(ACT_ADD, 8'h00, 16'h0000);
    send_item(ACT_ADD, 8'h5A, 16'd100);
    send_item(ACT_ADD, 8'hA5, 16'd100);
    send_item(ACT_ADD, 8'hAA, 16'h5555);
    send_item(ACT_ADD, 8'h55, 16'hAAAA);
    send_item(ACT_DISPATCH, 8'hFF, 16'hFFFF);
    send_item(ACT_DISPATCH, 8'hFF, 16'hFFFF);
    send_item(ACT_FINISH, 8'hFF, 16'hFFFF);
    send_item(ACT_DISPATCH, 8'h00, 16'h0000);
    settle();
    write_idle(16'd12345);
    send_item(ACT_FINISH, 8'h00, 16'h0000);
    send_item(ACT_DISPATCH, 8'h00, 16'h0000);
    send_item(ACT_DISPATCH, 8'h00, 16'h0000);
    send_item(ACT_FINISH, 8'h00, 16'h0000);

    for (int seg = 0; seg < 9; seg++) begin
      settle();
      case (seg / 3)
        0: begin
          tx_idle_pct = 13;
          rx_idle_pct = 76;
        end
        1: begin
          tx_idle_pct = 76;
          rx_idle_pct = 13;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      write_idle(levels[seg]);
      run_segment(SEG_ITEMS);
    end

    settle();
    if (fail_count == 0) begin
      $display("preemptive_priority_task_queue_unit: match");
    end else begin
      $display("preemptive_priority_task_queue_unit: mismatch");
    end
    $finish;
  end

endmodule
